// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the watchdog checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, disabled while arst_n is low.
`define WDTFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A signal keeps its value into the cycle after a condition is seen.
`define WDTFS_ASSERT_HOLD(lbl, cond, sig, msg) \
	`WDTFS_ASSERT(lbl, (cond) |=> $stable(sig), msg)

`endif

// ----- rtl/core/wdtfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Watchdog package
// Types and fixed constants shared by the watchdog timer modules.
// ----------------------------------------------------------------------------
package wdtfs_pkg;

	// Width of a period code field.
	localparam int CODE_WIDTH = 4;

	// A period code c selects a timeout of 2^(PERIOD_BASE - c) ticks.
	localparam int PERIOD_BASE = 31;

	// Two-word feed sequence.
	localparam logic [7:0] FEED_FIRST  = 8'hA5;
	localparam logic [7:0] FEED_SECOND = 8'h5A;

	// Item kinds.
	typedef enum logic [1:0] {
		MODE_TICK      = 2'd0,
		MODE_CTRL      = 2'd1,
		MODE_FEED      = 2'd2,
		MODE_INT_CLEAR = 2'd3
	} mode_t;

	// Stored control register.
	typedef struct packed {
		logic                  enable;
		logic                  int_enable;
		logic                  reset_enable;
		logic [CODE_WIDTH-1:0] int_code;
		logic [CODE_WIDTH-1:0] reset_code;
	} ctrl_t;

	// Sticky flags and feed sequence state.
	typedef struct packed {
		logic feed_armed;
		logic int_flag;
		logic reset_flag;
	} flags_t;

endpackage

// ----- rtl/core/wdtfs_step.sv -----
// ----------------------------------------------------------------------------
// Watchdog next-state logic
// Applies one item to the stored watchdog state in a single combinational pass.
// ----------------------------------------------------------------------------
module wdtfs_step #(
	parameter int COUNT_WIDTH  = 32,
	parameter int PERIOD_CODES = 16
) (
	input  logic [1:0]                       mode,
	input  logic                             wr_enable,
	input  logic                             wr_int_enable,
	input  logic                             wr_reset_enable,
	input  logic [wdtfs_pkg::CODE_WIDTH-1:0] wr_int_period,
	input  logic [wdtfs_pkg::CODE_WIDTH-1:0] wr_reset_period,
	input  logic [7:0]                       feed_word,
	input  wdtfs_pkg::ctrl_t                 ctrl_cur,
	input  wdtfs_pkg::flags_t                flags_cur,
	input  logic [COUNT_WIDTH-1:0]           count_cur,
	output wdtfs_pkg::ctrl_t                 ctrl_nxt,
	output wdtfs_pkg::flags_t                flags_nxt,
	output logic [COUNT_WIDTH-1:0]           count_nxt
);

	localparam int CW = wdtfs_pkg::CODE_WIDTH;

	logic [COUNT_WIDTH-1:0] count_inc;
	logic                   int_hit;
	logic                   reset_hit;

	// Clamp a written period code to the last supported code.
	function automatic logic [CW-1:0] clamp_code(input logic [CW-1:0] code);
		if ({1'b0, code} >= (CW+1)'(PERIOD_CODES))
			return CW'(PERIOD_CODES - 1);
		return code;
	endfunction

	// The count has reached 2^(base - code) when any bit at or above that
	// position is set; positions beyond the counter are never reached.
	function automatic logic reached(input logic [COUNT_WIDTH-1:0] cnt,
			input logic [CW-1:0] code);
		logic [4:0] sh;
		sh = 5'(wdtfs_pkg::PERIOD_BASE) - {1'b0, code};
		return (cnt >> sh) != '0;
	endfunction

	// Saturating increment and expiry checks on the incremented count.
	assign count_inc = (count_cur == '1) ? count_cur : count_cur + 1'b1;
	assign int_hit   = reached(count_inc, ctrl_cur.int_code);
	assign reset_hit = reached(count_inc, ctrl_cur.reset_code);

	// Apply the item according to its kind.
	always_comb begin
		ctrl_nxt  = ctrl_cur;
		flags_nxt = flags_cur;
		count_nxt = count_cur;
		case (wdtfs_pkg::mode_t'(mode))
			wdtfs_pkg::MODE_TICK: begin
				if (ctrl_cur.enable) begin
					count_nxt = count_inc;
					if (ctrl_cur.int_enable && int_hit)
						flags_nxt.int_flag = 1'b1;
					if (ctrl_cur.reset_enable && reset_hit)
						flags_nxt.reset_flag = 1'b1;
				end
			end
			wdtfs_pkg::MODE_CTRL: begin
				ctrl_nxt.enable       = wr_enable;
				ctrl_nxt.int_enable   = wr_int_enable;
				ctrl_nxt.reset_enable = wr_reset_enable;
				ctrl_nxt.int_code     = clamp_code(wr_int_period);
				ctrl_nxt.reset_code   = clamp_code(wr_reset_period);
			end
			wdtfs_pkg::MODE_FEED: begin
				if (flags_cur.feed_armed && feed_word == wdtfs_pkg::FEED_SECOND) begin
					count_nxt            = '0;
					flags_nxt.reset_flag = 1'b0;
					flags_nxt.feed_armed = 1'b0;
				end else begin
					flags_nxt.feed_armed = (feed_word == wdtfs_pkg::FEED_FIRST);
				end
			end
			default: begin
				flags_nxt.int_flag = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/core/watchdog_timer_with_feed_sequence_unit.sv -----
// ----------------------------------------------------------------------------
// Watchdog timer with feed sequence
// Tick-driven watchdog with interrupt and reset timeouts and a two-word feed.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the input is not stalled and
// returns one status item for each, in order. An accepted item is held in an
// input register and applied to the watchdog state in one pass of logic that
// also loads the status register, from which the status item is offered at the
// output. The input stalls only while a status item waits at the output and
// another item is already held in the input register.
module watchdog_timer_with_feed_sequence_unit #(
	parameter int COUNT_WIDTH  = 32,
	parameter int PERIOD_CODES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       mode,
	input  logic                             wr_enable,
	input  logic                             wr_int_enable,
	input  logic                             wr_reset_enable,
	input  logic [wdtfs_pkg::CODE_WIDTH-1:0] wr_int_period,
	input  logic [wdtfs_pkg::CODE_WIDTH-1:0] wr_reset_period,
	input  logic [7:0]                       feed_word,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             running,
	output logic                             int_selected,
	output logic                             reset_selected,
	output logic [wdtfs_pkg::CODE_WIDTH-1:0] int_code,
	output logic [wdtfs_pkg::CODE_WIDTH-1:0] reset_code,
	output logic                             int_pending,
	output logic                             reset_request,
	output logic [31:0]                      elapsed_ticks
);

	localparam int CW = wdtfs_pkg::CODE_WIDTH;

	// Input register stage.
	logic          item_valid_s1;
	logic [1:0]    mode_s1;
	logic          wr_enable_s1;
	logic          wr_int_enable_s1;
	logic          wr_reset_enable_s1;
	logic [CW-1:0] wr_int_period_s1;
	logic [CW-1:0] wr_reset_period_s1;
	logic [7:0]    feed_word_s1;

	// Watchdog state.
	wdtfs_pkg::ctrl_t       ctrl_q;
	wdtfs_pkg::flags_t      flags_q;
	logic [COUNT_WIDTH-1:0] count_q;

	wdtfs_pkg::ctrl_t       ctrl_nxt;
	wdtfs_pkg::flags_t      flags_nxt;
	logic [COUNT_WIDTH-1:0] count_nxt;

	// Result register.
	logic                   res_valid_q;
	wdtfs_pkg::ctrl_t       res_ctrl_q;
	wdtfs_pkg::flags_t      res_flags_q;
	logic [COUNT_WIDTH-1:0] res_count_q;

	logic advance;

	// The held item moves on whenever the result register is free or emptying.
	assign advance  = item_valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall = item_valid_s1 && !advance;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			item_valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1            <= mode;
			wr_enable_s1       <= wr_enable;
			wr_int_enable_s1   <= wr_int_enable;
			wr_reset_enable_s1 <= wr_reset_enable;
			wr_int_period_s1   <= wr_int_period;
			wr_reset_period_s1 <= wr_reset_period;
			feed_word_s1       <= feed_word;
		end
	end

	wdtfs_step #(
		.COUNT_WIDTH  (COUNT_WIDTH),
		.PERIOD_CODES (PERIOD_CODES)
	) u_step (
		.mode            (mode_s1),
		.wr_enable       (wr_enable_s1),
		.wr_int_enable   (wr_int_enable_s1),
		.wr_reset_enable (wr_reset_enable_s1),
		.wr_int_period   (wr_int_period_s1),
		.wr_reset_period (wr_reset_period_s1),
		.feed_word       (feed_word_s1),
		.ctrl_cur        (ctrl_q),
		.flags_cur       (flags_q),
		.count_cur       (count_q),
		.ctrl_nxt        (ctrl_nxt),
		.flags_nxt       (flags_nxt),
		.count_nxt       (count_nxt)
	);

	// Watchdog state update, one item per advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= '0;
			flags_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			ctrl_q  <= ctrl_nxt;
			flags_q <= flags_nxt;
			count_q <= count_nxt;
		end
	end

	// Result valid: set on advance, cleared once the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload is the state after the item.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_ctrl_q  <= ctrl_nxt;
			res_flags_q <= flags_nxt;
			res_count_q <= count_nxt;
		end
	end

	// Output ports.
	assign out_valid      = res_valid_q;
	assign running        = res_ctrl_q.enable;
	assign int_selected   = res_ctrl_q.int_enable;
	assign reset_selected = res_ctrl_q.reset_enable;
	assign int_code       = res_ctrl_q.int_code;
	assign reset_code     = res_ctrl_q.reset_code;
	assign int_pending    = res_flags_q.int_flag;
	assign reset_request  = res_flags_q.reset_flag;
	assign elapsed_ticks  = 32'(res_count_q);

endmodule

// ----- rtl/core/wdtfs_checker.sv -----
// ----------------------------------------------------------------------------
// Watchdog port checker
// Concurrent checks on the watchdog ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wdtfs_checker #(
	parameter int PERIOD_CODES = 16
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             running,
	input logic                             int_selected,
	input logic                             reset_selected,
	input logic [wdtfs_pkg::CODE_WIDTH-1:0] int_code,
	input logic [wdtfs_pkg::CODE_WIDTH-1:0] reset_code,
	input logic                             int_pending,
	input logic                             reset_request,
	input logic [31:0]                      elapsed_ticks
);

	// A stalled result item stays offered.
	`WDTFS_ASSERT(a_out_hold, (out_valid && out_stall) |=> out_valid, "stalled result dropped")

	// A stalled result item keeps its payload.
	`WDTFS_ASSERT_HOLD(a_out_stable, out_valid && out_stall, ({running, int_selected, reset_selected, int_code, reset_code, int_pending, reset_request, elapsed_ticks}), "stalled result changed")

	// An accepted item is always followed by a result offered at the output.
	`WDTFS_ASSERT(a_latency, (in_valid && !in_stall) |-> ##2 out_valid, "result missing after item")

	// Stored period codes never exceed the last supported code.
	`WDTFS_ASSERT(a_code_range, out_valid |-> ({1'b0, int_code} < 5'(PERIOD_CODES) && {1'b0, reset_code} < 5'(PERIOD_CODES)), "period code out of range")

endmodule

bind watchdog_timer_with_feed_sequence_unit wdtfs_checker #(
	.PERIOD_CODES (PERIOD_CODES)
) u_wdtfs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.running        (running),
	.int_selected   (int_selected),
	.reset_selected (reset_selected),
	.int_code       (int_code),
	.reset_code     (reset_code),
	.int_pending    (int_pending),
	.reset_request  (reset_request),
	.elapsed_ticks  (elapsed_ticks)
);
